// ===== rtl/core/afi_pkg.sv =====
`timescale 1ns / 1ps
// afi_pkg: widths, register indexes, play mode codes and result type for the
// animation frame index block. No dependencies.

package afi_pkg;

  localparam int TIME_W         = 31;
  localparam int DUR_W          = 16;
  localparam int MODE_W         = 3;
  localparam int COUNT_W        = 9;
  localparam int INDEX_W        = 8;
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int IN_TDATA_W     = 32;
  localparam int MAX_FRAMES_DEF = 256;

  localparam logic [CFG_ADDR_W-1:0] CFG_DURATION = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NORMAL        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REVERSED      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOP          = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOOP_REVERSED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PINGPONG      = 3'd4;

  typedef struct packed {
    logic               empty_error;
    logic [INDEX_W-1:0] frame_index;
  } result_t;

endpackage

// ===== rtl/core/afi_div.sv =====
`timescale 1ns / 1ps
// afi_div: pipelined restoring divider, one quotient bit per stage, with a
// sideband carried alongside each word. Depends on afi_pkg for default widths.

module afi_div #(
  parameter int NW = afi_pkg::TIME_W,
  parameter int DW = afi_pkg::DUR_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] out_side
);

  logic          vld_s  [NW];
  logic [NW-1:0] num_s  [NW];
  logic [NW-1:0] quo_s  [NW];
  logic [DW-1:0] rem_s  [NW];
  logic [SW-1:0] side_s [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic          vld_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] rem_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          take;

    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign num_in  = num;
      assign quo_in  = '0;
      assign rem_in  = '0;
      assign side_in = side;
    end else begin : g_next
      assign vld_in  = vld_s[g-1];
      assign num_in  = num_s[g-1];
      assign quo_in  = quo_s[g-1];
      assign rem_in  = rem_s[g-1];
      assign side_in = side_s[g-1];
    end

    always_comb begin
      shifted = {rem_in, num_in[NW-1]};
      diff    = shifted - {1'b0, den};
      take    = (shifted >= {1'b0, den});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g] <= 1'b0;
      end else if (en) begin
        vld_s[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g]  <= take ? diff[DW-1:0] : shifted[DW-1:0];
        num_s[g]  <= num_in << 1;
        quo_s[g]  <= {quo_in[NW-2:0], take};
        side_s[g] <= side_in;
      end
    end
  end

  assign out_valid = vld_s[NW-1];
  assign quo       = quo_s[NW-1];
  assign rem       = rem_s[NW-1];
  assign out_side  = side_s[NW-1];

endmodule

// ===== rtl/core/animation_frame_index.sv =====
`timescale 1ns / 1ps
// Animation key-frame selector: elapsed time in, frame index and empty flag out.
// Depends on afi_pkg and afi_div.
//
// Takes one word per cycle while s_axis_tready is high and returns one word per
// input word, in order, after passing through an input register, a 31-stage
// divider for time / duration, one compare stage, a second 31-stage divider
// for the wrap modulus, one index stage and the output register. A two-entry
// output buffer lets the pipeline keep taking words after the output stalls,
// until a word lands in its second entry. Write the configuration
// registers only while no word is in flight.

module animation_frame_index #(
  parameter int MAX_FRAMES = afi_pkg::MAX_FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [afi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [afi_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [afi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [30:0] elapsed_time
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [afi_pkg::INDEX_W-1:0]       m_axis_tdata,  // [7:0] frame_index
  output logic                              m_axis_tuser   // [0] empty_error
);

  localparam int LW = $clog2(MAX_FRAMES + 1);
  localparam int PW = $clog2(2 * MAX_FRAMES - 1);
  localparam int TW = afi_pkg::TIME_W;
  localparam int SW = LW + 3;

  logic [afi_pkg::DUR_W-1:0]   frame_duration;
  logic [afi_pkg::MODE_W-1:0]  play_mode;
  logic [afi_pkg::COUNT_W-1:0] frame_count;

  logic [afi_pkg::DUR_W-1:0] dur_eff;
  logic [LW-1:0]             len;
  logic [LW-1:0]             len_m1;
  logic [PW-1:0]             period;
  logic [PW-1:0]             mod_den;
  logic                      len_zero;
  logic                      len_one;

  logic          en;
  logic          in_valid;
  logic [TW-1:0] in_time;

  logic          q_valid;
  logic [TW-1:0] q;
  logic [1:0]    q_side;

  logic          mid_valid;
  logic [TW-1:0] mid_q;
  logic [SW-1:0] mid_side;

  logic          r_valid;
  logic [PW-1:0] r;
  logic [SW-1:0] r_side;
  logic          r_empty;
  logic          r_one;
  logic          r_ge;
  logic [LW-1:0] r_qlo;
  logic [LW-1:0] idx;

  logic             fin_valid;
  afi_pkg::result_t fin_data;
  logic             skid_valid;
  afi_pkg::result_t skid_data;
  afi_pkg::result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_duration <= afi_pkg::DUR_W'(1);
      play_mode      <= afi_pkg::MODE_NORMAL;
      frame_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        afi_pkg::CFG_DURATION: frame_duration <= cfg_data;
        afi_pkg::CFG_MODE:     play_mode      <= cfg_data[afi_pkg::MODE_W-1:0];
        afi_pkg::CFG_COUNT:    frame_count    <= cfg_data[afi_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dur_eff = (frame_duration == '0) ? afi_pkg::DUR_W'(1) : frame_duration;
    if (int'(frame_count) > MAX_FRAMES) begin
      len = LW'(MAX_FRAMES);
    end else begin
      len = LW'(frame_count);
    end
    len_m1   = len - LW'(1);
    period   = (PW'(len) << 1) - PW'(2);
    mod_den  = (play_mode == afi_pkg::MODE_PINGPONG) ? period : PW'(len);
    len_zero = (len == '0);
    len_one  = (len == LW'(1));
  end

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_time <= s_axis_tdata[TW-1:0];
    end
  end

  afi_div #(
    .NW(TW),
    .DW(afi_pkg::DUR_W),
    .SW(2)
  ) u_div_time (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .num      (in_time),
    .den      (dur_eff),
    .side     ({len_zero, len_one}),
    .out_valid(q_valid),
    .quo      (q),
    .rem      (),
    .out_side (q_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_q    <= q;
      mid_side <= {q_side, (q >= TW'(len_m1)), q[LW-1:0]};
    end
  end

  afi_div #(
    .NW(TW),
    .DW(PW),
    .SW(SW)
  ) u_div_wrap (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (mid_valid),
    .num      (mid_q),
    .den      (mod_den),
    .side     (mid_side),
    .out_valid(r_valid),
    .quo      (),
    .rem      (r),
    .out_side (r_side)
  );

  always_comb begin
    {r_empty, r_one, r_ge, r_qlo} = r_side;
    case (play_mode)
      afi_pkg::MODE_REVERSED:      idx = r_ge ? '0 : (len_m1 - r_qlo);
      afi_pkg::MODE_LOOP:          idx = LW'(r);
      afi_pkg::MODE_LOOP_REVERSED: idx = len_m1 - LW'(r);
      afi_pkg::MODE_PINGPONG:      idx = (r >= PW'(len)) ? LW'(period - r) : LW'(r);
      default:                     idx = r_ge ? len_m1 : r_qlo;
    endcase
    if (r_empty || r_one) begin
      idx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_data.frame_index <= afi_pkg::INDEX_W'(idx);
      fin_data.empty_error <= r_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= fin_valid;
      end
    end else if (fin_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : fin_data;
    end else if (!skid_valid) begin
      skid_data <= fin_data;
    end
  end

  assign m_axis_tdata = out_data.frame_index;
  assign m_axis_tuser = out_data.empty_error;

endmodule
